/* sv/kcv_pkg.sv */
`timescale 1ns / 1ps

package kcv_pkg;

  localparam int AXES      = 3;
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int DT_W      = 24;
  localparam int AXW       = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int EW        = DW + 8;          // headroom for exact sums
  localparam int NUM_W     = DW + FRAC_BITS;  // dividend magnitude
  localparam int DEN_W     = DW + 2;          // divisor (innovation variance)
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR   = 2'd2;

  localparam logic [DW-1:0] PROC_NOISE_RST = 32'd655;
  localparam logic [DW-1:0] MEAS_NOISE_RST = 32'd6554;
  localparam logic [DW-1:0] INIT_ERR_RST   = 32'd65536;

  typedef logic signed [DW-1:0] word_t;

  localparam word_t SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_FIRST, OP_M_VDT, OP_W_P, OP_W_C01N, OP_W_M1, OP_W_C00N,
    OP_DIV0, OP_K0, OP_DIV1, OP_K1, OP_M_K0E, OP_W_POS, OP_W_VEL, OP_W_C00,
    OP_W_C01, OP_W_C11, OP_OUT
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [AXW-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } sts_t;

  // saturate a wide signed value to the word range
  function automatic word_t sat_w(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    hi = EW'(SMAX);
    lo = EW'(SMIN);
    if (v > hi) return SMAX;
    if (v < lo) return SMIN;
    return v[DW-1:0];
  endfunction

  // product magnitude rounded half away from zero, then saturated
  function automatic word_t round_sat(input logic signed [2*DW-1:0] p);
    logic [2*DW-1:0] mag;
    logic [2*DW-1:0] r;
    mag = p[2*DW-1] ? (~p + (2*DW)'(1)) : p;
    r   = (mag + ((2*DW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (p[2*DW-1]) begin
      if (r > (2*DW)'({1'b1, {(DW-1){1'b0}}})) return SMIN;
      return (~r[DW-1:0]) + 1'b1;
    end
    if (r > (2*DW)'(SMAX)) return SMAX;
    return r[DW-1:0];
  endfunction

endpackage

/* sv/kcv_in_if.sv */
`timescale 1ns / 1ps

interface kcv_in_if import kcv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] pos_x;
  logic signed [DW-1:0] pos_y;
  logic signed [DW-1:0] pos_z;
  logic [DT_W-1:0]      time_step;

  modport source (output valid, pos_x, pos_y, pos_z, time_step, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, time_step, output ready);
endinterface

/* sv/kcv_out_if.sv */
`timescale 1ns / 1ps

interface kcv_out_if import kcv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] est_x;
  logic signed [DW-1:0] est_y;
  logic signed [DW-1:0] est_z;

  modport source (output valid, est_x, est_y, est_z, input ready);
  modport sink   (input valid, est_x, est_y, est_z, output ready);
endinterface

/* sv/kcv_div.sv */
`timescale 1ns / 1ps

// restoring divide, one quotient bit per cycle on magnitudes
module kcv_div import kcv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  output logic                    busy_o,
  output logic                    done_o,
  output word_t                   quot_o
);

  logic             busy_q, done_q, neg_q, zero_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] nq_q;   // dividend bits shift out, quotient bits shift in
  logic [DEN_W-1:0] dmag_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, nq_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q   <= num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
      dmag_q <= den_i[DEN_W-1] ? (~den_i + 1'b1) : den_i;
      neg_q  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      zero_q <= (den_i == '0);
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(rem_sh - {1'b0, dmag_q}) : rem_sh[DEN_W-1:0];
      nq_q  <= {nq_q[NUM_W-2:0], fits};
    end
  end

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (neg_q) begin
      if (nq_q > NUM_W'({1'b1, {(DW-1){1'b0}}})) quot_o = SMIN;
      else quot_o = (~nq_q[DW-1:0]) + 1'b1;
    end else begin
      if (nq_q > NUM_W'(SMAX)) quot_o = SMAX;
      else quot_o = nq_q[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

/* sv/kcv_dp.sv */
`timescale 1ns / 1ps

module kcv_dp import kcv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  word_t                meas_i [AXES],
  input  logic [DT_W-1:0]      dt_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DW-1:0]        cfg_data_i,
  output word_t                est_o [AXES]
);

  logic [DW-1:0] pn_q, mn_q, ie_q;
  word_t pos_q [AXES];
  word_t vel_q [AXES];
  word_t c00_q [AXES];
  word_t c01_q [AXES];
  word_t c11_q [AXES];
  word_t meas_q [AXES];
  word_t est_q [AXES];
  logic [DT_W-1:0] dt_q;

  word_t p_q, c01n_q, m1_q, c00n_q, c11n_q, e_q, k0_q, k1_q;
  logic signed [2*DW-1:0] prod_q, prod_d;
  word_t ma, mb, rnd, dtw, quot;
  word_t pos_c, vel_c, c00_c, c01_c, c11_c, meas_c;
  logic [DW-1:0] ie_new;
  word_t ie_sat;
  logic cfg_hit;
  logic signed [DEN_W-1:0] den;
  logic signed [NUM_W-1:0] num;
  logic div_start, div_busy, div_done;
  logic signed [EW-1:0] q_ext;

  assign pos_c  = pos_q[cmd_i.axis];
  assign vel_c  = vel_q[cmd_i.axis];
  assign c00_c  = c00_q[cmd_i.axis];
  assign c01_c  = c01_q[cmd_i.axis];
  assign c11_c  = c11_q[cmd_i.axis];
  assign meas_c = meas_q[cmd_i.axis];
  assign dtw    = $signed({{(DW-DT_W){1'b0}}, dt_q});
  assign rnd    = round_sat(prod_q);
  assign q_ext  = $signed({{(EW-DW){1'b0}}, pn_q});

  always_comb begin
    case (cmd_i.op)
      OP_M_VDT:  begin ma = vel_c;  mb = dtw;    end
      OP_W_P:    begin ma = dtw;    mb = c11_c;  end
      OP_W_C01N: begin ma = dtw;    mb = c01_c;  end
      OP_W_M1:   begin ma = dtw;    mb = c01n_q; end
      OP_M_K0E:  begin ma = k0_q;   mb = e_q;    end
      OP_W_POS:  begin ma = k1_q;   mb = e_q;    end
      OP_W_VEL:  begin ma = k0_q;   mb = c00n_q; end
      OP_W_C00:  begin ma = k0_q;   mb = c01n_q; end
      OP_W_C01:  begin ma = k1_q;   mb = c01n_q; end
      default:   begin ma = '0;     mb = '0;     end
    endcase
  end

  assign prod_d = ma * mb;

  // innovation variance s = c00' + r, never saturated
  assign den = $signed({{(DEN_W-DW){c00n_q[DW-1]}}, c00n_q})
             + $signed({{(DEN_W-DW){1'b0}}, mn_q});
  assign num = (cmd_i.op == OP_DIV1) ? $signed({c01n_q, {FRAC_BITS{1'b0}}})
                                     : $signed({c00n_q, {FRAC_BITS{1'b0}}});
  assign div_start = (cmd_i.op == OP_DIV0) || (cmd_i.op == OP_DIV1);

  kcv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_PROC_NOISE || cfg_idx_i == CFG_MEAS_NOISE
                                || cfg_idx_i == CFG_INIT_ERR);
  assign ie_new  = (cfg_idx_i == CFG_INIT_ERR) ? cfg_data_i : ie_q;
  assign ie_sat  = ie_new[DW-1] ? SMAX : ie_new;

  // filter state, noise registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q <= PROC_NOISE_RST;
      mn_q <= MEAS_NOISE_RST;
      ie_q <= INIT_ERR_RST;
      for (int i = 0; i < AXES; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        c00_q[i] <= INIT_ERR_RST;
        c01_q[i] <= '0;
        c11_q[i] <= INIT_ERR_RST;
      end
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        CFG_PROC_NOISE: pn_q <= cfg_data_i;
        CFG_MEAS_NOISE: mn_q <= cfg_data_i;
        default:        ie_q <= cfg_data_i;
      endcase
      for (int i = 0; i < AXES; i++) begin
        c00_q[i] <= ie_sat;
        c01_q[i] <= '0;
        c11_q[i] <= ie_sat;
      end
    end else begin
      case (cmd_i.op)
        OP_FIRST: begin
          for (int i = 0; i < AXES; i++) begin
            pos_q[i] <= meas_q[i];
            vel_q[i] <= '0;
          end
        end
        OP_W_POS: pos_q[cmd_i.axis] <= sat_w(EW'(p_q) + EW'(rnd));
        OP_W_VEL: vel_q[cmd_i.axis] <= sat_w(EW'(vel_c) + EW'(rnd));
        OP_W_C00: c00_q[cmd_i.axis] <= sat_w(EW'(c00n_q) - EW'(rnd));
        OP_W_C01: c01_q[cmd_i.axis] <= sat_w(EW'(c01n_q) - EW'(rnd));
        OP_W_C11: c11_q[cmd_i.axis] <= sat_w(EW'(c11n_q) - EW'(rnd));
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      OP_LOAD: begin
        for (int i = 0; i < AXES; i++) meas_q[i] <= meas_i[i];
        dt_q <= dt_i;
      end
      OP_W_P:    p_q    <= sat_w(EW'(pos_c) + EW'(rnd));
      OP_W_C01N: c01n_q <= sat_w(EW'(c01_c) + EW'(rnd));
      OP_W_M1:   m1_q   <= rnd;
      OP_W_C00N: begin
        c00n_q <= sat_w(EW'(c00_c) + EW'(m1_q) + EW'(rnd) + q_ext);
        c11n_q <= sat_w(EW'(c11_c) + q_ext);
        e_q    <= sat_w(EW'(meas_c) - EW'(p_q));
      end
      OP_K0: k0_q <= quot;
      OP_K1: k1_q <= quot;
      OP_OUT: begin
        for (int i = 0; i < AXES; i++) est_q[i] <= pos_q[i];
      end
      default: ;
    endcase
  end

  assign est_o = est_q;

endmodule

/* sv/kcv_ctrl.sv */
`timescale 1ns / 1ps

module kcv_ctrl import kcv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_FIRST, ST_M_VDT, ST_W_P, ST_W_C01N, ST_W_M1, ST_W_C00N,
    ST_DIV0, ST_WAIT0, ST_DIV1, ST_WAIT1, ST_M_K0E, ST_W_POS, ST_W_VEL,
    ST_W_C00, ST_W_C01, ST_W_C11, ST_OUT
  } state_e;

  state_e         state_q;
  logic [AXW-1:0] axis_q;
  logic           has_q;
  logic           out_valid_q;
  logic           slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.axis  = axis_q;

  always_comb begin
    case (state_q)
      ST_IDLE:   cmd_o.op = in_valid_i ? OP_LOAD : OP_NOP;
      ST_FIRST:  cmd_o.op = OP_FIRST;
      ST_M_VDT:  cmd_o.op = OP_M_VDT;
      ST_W_P:    cmd_o.op = OP_W_P;
      ST_W_C01N: cmd_o.op = OP_W_C01N;
      ST_W_M1:   cmd_o.op = OP_W_M1;
      ST_W_C00N: cmd_o.op = OP_W_C00N;
      ST_DIV0:   cmd_o.op = OP_DIV0;
      ST_WAIT0:  cmd_o.op = sts_i.div_done ? OP_K0 : OP_NOP;
      ST_DIV1:   cmd_o.op = OP_DIV1;
      ST_WAIT1:  cmd_o.op = sts_i.div_done ? OP_K1 : OP_NOP;
      ST_M_K0E:  cmd_o.op = OP_M_K0E;
      ST_W_POS:  cmd_o.op = OP_W_POS;
      ST_W_VEL:  cmd_o.op = OP_W_VEL;
      ST_W_C00:  cmd_o.op = OP_W_C00;
      ST_W_C01:  cmd_o.op = OP_W_C01;
      ST_W_C11:  cmd_o.op = OP_W_C11;
      ST_OUT:    cmd_o.op = slot_free ? OP_OUT : OP_NOP;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      has_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            has_q   <= 1'b1;
            axis_q  <= '0;
            state_q <= has_q ? ST_M_VDT : ST_FIRST;
          end
        end
        ST_FIRST:  state_q <= ST_OUT;
        ST_M_VDT:  state_q <= ST_W_P;
        ST_W_P:    state_q <= ST_W_C01N;
        ST_W_C01N: state_q <= ST_W_M1;
        ST_W_M1:   state_q <= ST_W_C00N;
        ST_W_C00N: state_q <= ST_DIV0;
        ST_DIV0:   state_q <= ST_WAIT0;
        ST_WAIT0:  if (sts_i.div_done) state_q <= ST_DIV1;
        ST_DIV1:   state_q <= ST_WAIT1;
        ST_WAIT1:  if (sts_i.div_done) state_q <= ST_M_K0E;
        ST_M_K0E:  state_q <= ST_W_POS;
        ST_W_POS:  state_q <= ST_W_VEL;
        ST_W_VEL:  state_q <= ST_W_C00;
        ST_W_C00:  state_q <= ST_W_C01;
        ST_W_C01:  state_q <= ST_W_C11;
        ST_W_C11: begin
          if (axis_q == AXW'(AXES - 1)) begin
            axis_q  <= '0;
            state_q <= ST_OUT;
          end else begin
            axis_q  <= axis_q + 1'b1;
            state_q <= ST_M_VDT;
          end
        end
        ST_OUT:    if (slot_free) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV0 || state_q == ST_DIV1) |-> !sts_i.div_busy)
    else $error("divider started while busy");

  a_div_idle_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sts_i.div_busy)
    else $error("divider running with no item in flight");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q <= AXW'(AXES - 1))
    else $error("axis index out of range");

  a_first_no_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRST) |=> (state_q == ST_OUT && !sts_i.div_busy))
    else $error("first item did not go straight to output");

endmodule

/* sv/constant_velocity_kalman_3d.sv */
`timescale 1ns / 1ps

// channel   dir  handshake        payload
// in_ch     in   valid / ready    pos_x, pos_y, pos_z, time_step
// out_ch    out  valid / ready    est_x, est_y, est_z
// cfg       in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// the first item after reset is loaded, copied into the position state and
// then into the result register; later items run the filter per axis, with the
// 48-step shift-subtract divider run twice per axis; one shared multiplier
// reset zeroes position and velocity and loads covariance and noise defaults
// a result waiting for out_ch.ready does not stop the next item's filter work

module constant_velocity_kalman_3d import kcv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kcv_in_if.sink               in_ch,
  kcv_out_if.source            out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DW-1:0]        cfg_data_i
);

  cmd_t  cmd;
  sts_t  sts;
  word_t meas [AXES];
  word_t est [AXES];

  assign meas[0] = in_ch.pos_x;
  assign meas[1] = in_ch.pos_y;
  assign meas[2] = in_ch.pos_z;

  assign out_ch.est_x = est[0];
  assign out_ch.est_y = est[1];
  assign out_ch.est_z = est[2];

  kcv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kcv_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .meas_i     (meas),
    .dt_i       (in_ch.time_step),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .est_o      (est)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import kcv_pkg::*;

  localparam int NUM_RANDOM   = 1425;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int LONG_HOLD    = 3000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic signed [DW-1:0] pz;
    logic [DT_W-1:0]      dt;
  } meas_t;

  typedef struct packed {
    logic signed [DW-1:0] ex;
    logic signed [DW-1:0] ey;
    logic signed [DW-1:0] ez;
  } est_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DW-1:0] cfg_data_i;

  kcv_in_if  in_ch ();
  kcv_out_if out_ch ();

  constant_velocity_kalman_3d dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // tracker copy of the filter state, 64-bit signed for exact sums
  longint trk_pos[AXES], trk_vel[AXES], trk_c00[AXES], trk_c01[AXES], trk_c11[AXES];
  bit     trk_valid;
  longint noise_q, noise_r, init_err;

  meas_t  pending_meas[$];
  est_t   expected_est[$];
  int     mismatches;
  bit     send_paused;
  bit     long_hold_req;
  int     burst_left, gap_left, hold_left;
  longint cycle_count;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clamp32((p < 0) ? -m : m);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    if (den == 0) return 0;
    return clamp32((num * (64'sd1 << FRAC_BITS)) / den);
  endfunction

  task automatic load_cov();
    longint init;
    init = clamp32(init_err);
    for (int i = 0; i < AXES; i++) begin
      trk_c00[i] = init;
      trk_c01[i] = 0;
      trk_c11[i] = init;
    end
  endtask

  function automatic est_t track_step(meas_t m);
    est_t   res;
    longint meas, dt, p, c01, c00, c11, s, k0, k1, e;
    dt = longint'(m.dt);
    for (int i = 0; i < AXES; i++) begin
      meas = (i == 0) ? longint'(m.px) : (i == 1) ? longint'(m.py) : longint'(m.pz);
      if (!trk_valid) begin
        trk_pos[i] = meas;
        trk_vel[i] = 0;
      end else begin
        p   = clamp32(trk_pos[i] + fx_mul(trk_vel[i], dt));
        c01 = clamp32(trk_c01[i] + fx_mul(dt, trk_c11[i]));
        c00 = clamp32(trk_c00[i] + fx_mul(dt, trk_c01[i]) + fx_mul(dt, c01) + noise_q);
        c11 = clamp32(trk_c11[i] + noise_q);
        s   = c00 + noise_r;
        k0  = fx_div(c00, s);
        k1  = fx_div(c01, s);
        e   = clamp32(meas - p);
        trk_pos[i] = clamp32(p + fx_mul(k0, e));
        trk_vel[i] = clamp32(trk_vel[i] + fx_mul(k1, e));
        trk_c00[i] = clamp32(c00 - fx_mul(k0, c00));
        trk_c01[i] = clamp32(c01 - fx_mul(k0, c01));
        trk_c11[i] = clamp32(c11 - fx_mul(k1, c01));
      end
    end
    trk_valid = 1'b1;
    res.ex = trk_pos[0][DW-1:0];
    res.ey = trk_pos[1][DW-1:0];
    res.ez = trk_pos[2][DW-1:0];
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: bursts and gaps, each accepted item is predicted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.pos_x     <= '0;
      in_ch.pos_y     <= '0;
      in_ch.pos_z     <= '0;
      in_ch.time_step <= '0;
      burst_left      <= 0;
      gap_left        <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_est.push_back(track_step(pending_meas.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_meas.size() > 0 && !send_paused) begin
          in_ch.valid     <= 1'b1;
          in_ch.pos_x     <= pending_meas[0].px;
          in_ch.pos_y     <= pending_meas[0].py;
          in_ch.pos_z     <= pending_meas[0].pz;
          in_ch.time_step <= pending_meas[0].dt;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (long_hold_req && hold_left == 0) begin
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else begin
      out_ch.ready <= (cycle_count % 3000 < 1500) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_est.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected estimate x=%0d y=%0d z=%0d",
                     out_ch.est_x, out_ch.est_y, out_ch.est_z);
        end else begin
          est_t want;
          want = expected_est.pop_front();
          if (want.ex !== out_ch.est_x || want.ey !== out_ch.est_y ||
              want.ez !== out_ch.est_z) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("estimate mismatch: exp %0d %0d %0d got %0d %0d %0d",
                       want.ex, want.ey, want.ez,
                       out_ch.est_x, out_ch.est_y, out_ch.est_z);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [DW-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return DW'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DT_W'($urandom);
      default: return DT_W'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic queue_meas(logic [DW-1:0] x, logic [DW-1:0] y, logic [DW-1:0] z,
                            logic [DT_W-1:0] dt);
    meas_t m;
    m.px = x; m.py = y; m.pz = z; m.dt = dt;
    pending_meas.push_back(m);
  endtask

  task automatic drain();
    while (pending_meas.size() > 0 || in_ch.valid || expected_est.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PROC_NOISE) noise_q = longint'(val);
    else if (idx == CFG_MEAS_NOISE) noise_r = longint'(val);
    else if (idx == CFG_INIT_ERR) init_err = longint'(val);
    if (idx == CFG_PROC_NOISE || idx == CFG_MEAS_NOISE || idx == CFG_INIT_ERR) load_cov();
  endtask

  task automatic random_track(int n);
    logic [DW-1:0] x, y, z;
    x = rand_pos(); y = rand_pos(); z = rand_pos();
    for (int i = 0; i < n; i++) begin
      // mostly smooth motion with noise, sometimes a wild jump
      if ($urandom_range(0, 9) == 0) begin
        x = rand_pos(); y = rand_pos(); z = rand_pos();
      end else begin
        x = x + DW'($signed($urandom_range(0, 4000)) - 2000);
        y = y + DW'($signed($urandom_range(0, 4000)) - 2000);
        z = z + DW'($signed($urandom_range(0, 4000)) - 2000);
      end
      queue_meas(x, y, z, rand_dt());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PROC_NOISE;
    cfg_data_i    = '0;
    mismatches    = 0;
    cycle_count   = 0;
    send_paused   = 1'b0;
    long_hold_req = 1'b0;
    noise_q  = longint'(PROC_NOISE_RST);
    noise_r  = longint'(MEAS_NOISE_RST);
    init_err = longint'(INIT_ERR_RST);
    trk_valid = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      trk_pos[i] = 0;
      trk_vel[i] = 0;
    end
    load_cov();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pass-through first item, extremes of fields
    queue_meas(32'h0001_0000, 32'hffff_0000, 32'h0, 24'h01_0000);
    queue_meas(32'h7fff_ffff, 32'h8000_0000, 32'h0, 24'h00_0000);
    queue_meas(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 24'hff_ffff);
    queue_meas(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 24'hff_ffff);
    queue_meas(32'h0, 32'h0, 32'h0, 24'h00_8000);
    queue_meas(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 24'haa_aaaa);
    queue_meas(32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987, 24'h55_5555);
    drain();

    // zero noise: zero innovation variance case
    write_reg(CFG_PROC_NOISE, 32'h0);
    write_reg(CFG_MEAS_NOISE, 32'h0);
    write_reg(CFG_INIT_ERR, 32'h0);
    queue_meas(32'h0002_0000, 32'h0, 32'hfffe_0000, 24'h0);
    queue_meas(32'h0003_0000, 32'h1, 32'hfffd_0000, 24'h01_0000);
    drain();

    // all-ones registers: initial error saturates, noise taken as large unsigned values
    write_reg(CFG_INIT_ERR, 32'hffff_ffff);
    write_reg(CFG_PROC_NOISE, 32'hffff_ffff);
    write_reg(CFG_MEAS_NOISE, 32'hffff_ffff);
    queue_meas(32'h0010_0000, 32'hfff0_0000, 32'h0, 24'h00_4000);
    queue_meas(32'h0011_0000, 32'hffef_0000, 32'h1, 24'h00_4000);
    queue_meas(32'h7000_0000, 32'h9000_0000, 32'h0, 24'hff_ffff);
    drain();

    // random phases through several register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_PROC_NOISE, (ph % 3 == 0) ? DW'($urandom) : DW'($urandom_range(0, 70000)));
      write_reg(CFG_MEAS_NOISE, (ph % 4 == 1) ? DW'($urandom) : DW'($urandom_range(0, 300000)));
      write_reg(CFG_INIT_ERR, (ph == 5) ? 32'h0 : DW'($urandom_range(0, 1 << 20)));
      if (ph == 2) long_hold_req = 1'b1;
      random_track(NUM_RANDOM / 8);
      if (ph == 2) begin
        repeat (20) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      if (ph == 4) begin
        // sender waits until every estimate has come back
        while (pending_meas.size() > NUM_RANDOM / 16) @(posedge clk_i);
        send_paused = 1'b1;
        while (in_ch.valid || expected_est.size() > 0) @(posedge clk_i);
        send_paused = 1'b0;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
